>>> src/rgbhsv_pkg.sv
// Shared types, constants and the divider step for the RGB to HSV pixel converter.
// No dependencies.
`default_nettype none

package rgbhsv_pkg;

  localparam int unsigned CHAN_W = 8;
  localparam int unsigned HUE_W  = 15;
  localparam int unsigned SAT_W  = 17;

  // hue offset code, in steps of 120 degrees
  typedef enum logic [1:0] {
    OFS_0   = 2'd0,
    OFS_120 = 2'd1,
    OFS_240 = 2'd2,
    OFS_360 = 2'd3
  } ofs_e;

  typedef struct packed {
    logic              gray;
    logic              black;
    logic              neg;
    ofs_e              ofs;
    logic [CHAN_W-1:0] value;
  } side_t;

  // one restoring division step: returns {quotient bit, new remainder}
  function automatic logic [CHAN_W:0] div_step(input logic [CHAN_W-1:0] rem,
                                               input logic [CHAN_W-1:0] dvs,
                                               input logic              nbit);
    logic [CHAN_W:0] t;
    logic [CHAN_W:0] s;
    logic            ge;
    t  = {rem, nbit};
    s  = t - {1'b0, dvs};
    ge = (t >= {1'b0, dvs});
    div_step = ge ? {1'b1, s[CHAN_W-1:0]} : {1'b0, t[CHAN_W-1:0]};
  endfunction

endpackage

`default_nettype wire

>>> src/rgbhsv_front.sv
// Front end: max/min search, sector choice and divider operands, two register stages.
// Depends on rgbhsv_pkg.
`default_nettype none

module rgbhsv_front #(
  parameter int unsigned HF = 6,
  parameter int unsigned SF = 16,
  parameter int unsigned DS = 17
) (
  input  wire logic                             clk_i,
  input  wire logic                             rst_ni,
  input  wire logic                             valid_i,
  input  wire logic [rgbhsv_pkg::CHAN_W-1:0]    red_i,
  input  wire logic [rgbhsv_pkg::CHAN_W-1:0]    green_i,
  input  wire logic [rgbhsv_pkg::CHAN_W-1:0]    blue_i,
  output logic                                  valid_o,
  output rgbhsv_pkg::side_t                     side_o,
  output logic [rgbhsv_pkg::CHAN_W-1:0]         hrem_o,
  output logic [DS-1:0]                         hlo_o,
  output logic [rgbhsv_pkg::CHAN_W-1:0]         hdiv_o,
  output logic [rgbhsv_pkg::CHAN_W-1:0]         srem_o,
  output logic [DS-1:0]                         slo_o
);

  localparam int unsigned CW = rgbhsv_pkg::CHAN_W;
  localparam int unsigned NW = CW + DS;

  // stage 1
  logic [CW-1:0]    mx_d, mn_d, hi_d, lo_d;
  rgbhsv_pkg::ofs_e ofs_d;
  logic             v1_q;
  logic [CW-1:0]    mx_q, mn_q, hi_q, lo_q;
  rgbhsv_pkg::ofs_e ofs_q;

  always_comb begin
    mx_d = red_i;
    if (green_i > mx_d) mx_d = green_i;
    if (blue_i > mx_d)  mx_d = blue_i;
    mn_d = red_i;
    if (green_i < mn_d) mn_d = green_i;
    if (blue_i < mn_d)  mn_d = blue_i;
    if (mx_d == red_i) begin
      hi_d  = green_i;
      lo_d  = blue_i;
      ofs_d = rgbhsv_pkg::OFS_0;
    end else if (mx_d == green_i) begin
      hi_d  = blue_i;
      lo_d  = red_i;
      ofs_d = rgbhsv_pkg::OFS_120;
    end else begin
      hi_d  = red_i;
      lo_d  = green_i;
      ofs_d = rgbhsv_pkg::OFS_240;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      v1_q <= 1'b0;
    end else begin
      v1_q <= valid_i;
    end
  end

  always_ff @(posedge clk_i) begin
    mx_q  <= mx_d;
    mn_q  <= mn_d;
    hi_q  <= hi_d;
    lo_q  <= lo_d;
    ofs_q <= ofs_d;
  end

  // stage 2
  logic [CW-1:0]     delta, mag;
  logic              neg;
  logic [CW+5:0]     m60;
  logic [NW-1:0]     nh, ns;
  rgbhsv_pkg::side_t side_d;

  always_comb begin
    delta = mx_q - mn_q;
    neg   = (hi_q < lo_q);
    mag   = neg ? (lo_q - hi_q) : (hi_q - lo_q);
    m60   = ({6'b0, mag} << 6) - ({6'b0, mag} << 2);
    nh    = NW'(m60) << HF;
    ns    = NW'(delta) << SF;
    side_d.gray  = (delta == '0);
    side_d.black = (mx_q == '0);
    side_d.neg   = neg;
    side_d.ofs   = (neg && (ofs_q == rgbhsv_pkg::OFS_0)) ? rgbhsv_pkg::OFS_360 : ofs_q;
    side_d.value = mx_q;
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      valid_o <= 1'b0;
    end else begin
      valid_o <= v1_q;
    end
  end

  always_ff @(posedge clk_i) begin
    side_o <= side_d;
    hrem_o <= nh[NW-1:DS];
    hlo_o  <= nh[DS-1:0];
    hdiv_o <= delta;
    srem_o <= ns[NW-1:DS];
    slo_o  <= ns[DS-1:0];
  end

endmodule

`default_nettype wire

>>> src/rgbhsv_div.sv
// Pipelined restoring divider, one quotient bit per stage, hue and saturation lanes side by side.
// Depends on rgbhsv_pkg.
`default_nettype none

module rgbhsv_div #(
  parameter int unsigned DS = 17
) (
  input  wire logic                          clk_i,
  input  wire logic                          rst_ni,
  input  wire logic                          valid_i,
  input  wire rgbhsv_pkg::side_t             side_i,
  input  wire logic [rgbhsv_pkg::CHAN_W-1:0] hrem_i,
  input  wire logic [DS-1:0]                 hlo_i,
  input  wire logic [rgbhsv_pkg::CHAN_W-1:0] hdiv_i,
  input  wire logic [rgbhsv_pkg::CHAN_W-1:0] srem_i,
  input  wire logic [DS-1:0]                 slo_i,
  output logic                               valid_o,
  output rgbhsv_pkg::side_t                  side_o,
  output logic [DS-1:0]                      hq_o,
  output logic [DS-1:0]                      sq_o
);

  localparam int unsigned CW = rgbhsv_pkg::CHAN_W;

  logic              v_q  [DS];
  rgbhsv_pkg::side_t sd_q [DS];
  logic [CW-1:0]     hr_q [DS];
  logic [CW-1:0]     hd_q [DS];
  logic [CW-1:0]     sr_q [DS];
  logic [DS-1:0]     hn_q [DS];
  logic [DS-1:0]     sn_q [DS];

  for (genvar k = 0; k < DS; k++) begin : g_stage
    logic              v_in;
    rgbhsv_pkg::side_t sd_in;
    logic [CW-1:0]     hr_in, hd_in, sr_in;
    logic [DS-1:0]     hn_in, sn_in;
    logic [CW:0]       hst, sst;

    if (k == 0) begin : g_first
      assign v_in  = valid_i;
      assign sd_in = side_i;
      assign hr_in = hrem_i;
      assign hd_in = hdiv_i;
      assign sr_in = srem_i;
      assign hn_in = hlo_i;
      assign sn_in = slo_i;
    end else begin : g_next
      assign v_in  = v_q[k-1];
      assign sd_in = sd_q[k-1];
      assign hr_in = hr_q[k-1];
      assign hd_in = hd_q[k-1];
      assign sr_in = sr_q[k-1];
      assign hn_in = hn_q[k-1];
      assign sn_in = sn_q[k-1];
    end

    assign hst = rgbhsv_pkg::div_step(hr_in, hd_in, hn_in[DS-1]);
    assign sst = rgbhsv_pkg::div_step(sr_in, sd_in.value, sn_in[DS-1]);

    always_ff @(posedge clk_i or negedge rst_ni) begin
      if (!rst_ni) begin
        v_q[k] <= 1'b0;
      end else begin
        v_q[k] <= v_in;
      end
    end

    always_ff @(posedge clk_i) begin
      sd_q[k] <= sd_in;
      hd_q[k] <= hd_in;
      hr_q[k] <= hst[CW-1:0];
      sr_q[k] <= sst[CW-1:0];
      hn_q[k] <= {hn_in[DS-2:0], hst[CW]};
      sn_q[k] <= {sn_in[DS-2:0], sst[CW]};
    end
  end

  assign valid_o = v_q[DS-1];
  assign side_o  = sd_q[DS-1];
  assign hq_o    = hn_q[DS-1];
  assign sq_o    = sn_q[DS-1];

endmodule

`default_nettype wire

>>> src/rgbhsv_back.sv
// Back end: hue offset add and clamp, gray/black forcing, output register.
// Depends on rgbhsv_pkg.
`default_nettype none

module rgbhsv_back #(
  parameter int unsigned HF = 6,
  parameter int unsigned SF = 16,
  parameter int unsigned DS = 17
) (
  input  wire logic                          clk_i,
  input  wire logic                          rst_ni,
  input  wire logic                          valid_i,
  input  wire rgbhsv_pkg::side_t             side_i,
  input  wire logic [DS-1:0]                 hq_i,
  input  wire logic [DS-1:0]                 sq_i,
  output logic                               valid_o,
  output logic [rgbhsv_pkg::HUE_W-1:0]       hue_o,
  output logic [rgbhsv_pkg::SAT_W-1:0]       saturation_o,
  output logic [rgbhsv_pkg::CHAN_W-1:0]      value_o
);

  localparam int unsigned HW  = HF + 11;
  localparam int unsigned HQW = HF + 6;
  localparam int unsigned HUW = rgbhsv_pkg::HUE_W;
  localparam int unsigned SAW = rgbhsv_pkg::SAT_W;

  logic signed [HW-1:0] offv, qx, hs, hmax, hc;
  logic [HW+HUW-1:0]    hx;
  logic [DS+SAW-1:0]    sx;
  logic [SF:0]          sq;
  logic [HUW-1:0]       hue_d;
  logic [SAW-1:0]       sat_d;

  always_comb begin
    hmax = HW'(360) << HF;
    case (side_i.ofs)
      rgbhsv_pkg::OFS_0:   offv = '0;
      rgbhsv_pkg::OFS_120: offv = HW'(120) << HF;
      rgbhsv_pkg::OFS_240: offv = HW'(240) << HF;
      rgbhsv_pkg::OFS_360: offv = HW'(360) << HF;
      default:             offv = '0;
    endcase
    qx = HW'(hq_i[HQW-1:0]);
    hs = side_i.neg ? (offv - qx) : (offv + qx);
    if (side_i.gray || hs < 0) begin
      hc = '0;
    end else if (hs > hmax) begin
      hc = hmax;
    end else begin
      hc = hs;
    end
    hx    = {{HUW{1'b0}}, hc};
    hue_d = hx[HUW-1:0];
    sq    = sq_i[SF:0];
    sx    = (DS+SAW)'(sq);
    sat_d = side_i.black ? '0 : sx[SAW-1:0];
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      valid_o <= 1'b0;
    end else begin
      valid_o <= valid_i;
    end
  end

  always_ff @(posedge clk_i) begin
    hue_o        <= hue_d;
    saturation_o <= sat_d;
    value_o      <= side_i.value;
  end

endmodule

`default_nettype wire

>>> src/rgb_to_hsv_pixel.sv
// RGB to HSV pixel converter, top level. An item passes the front end, then the divider,
// which retires one quotient bit per stage, then the back end output register.
// Throughput one item per cycle; busy stays low
// and the receiver cannot stall. Reset clears all valid bits; items in flight are dropped.
// Depends on rgbhsv_pkg, rgbhsv_front, rgbhsv_div, rgbhsv_back.
`default_nettype none

module rgb_to_hsv_pixel #(
  parameter int unsigned HUE_FRAC_BITS = 6,
  parameter int unsigned SAT_FRAC_BITS = 16
) (
  input  wire logic                          clk_i,
  input  wire logic                          rst_ni,
  input  wire logic                          start,
  output logic                               busy,
  input  wire logic [rgbhsv_pkg::CHAN_W-1:0] red_i,
  input  wire logic [rgbhsv_pkg::CHAN_W-1:0] green_i,
  input  wire logic [rgbhsv_pkg::CHAN_W-1:0] blue_i,
  output logic                               valid_o,
  output logic [rgbhsv_pkg::HUE_W-1:0]       hue_o,
  output logic [rgbhsv_pkg::SAT_W-1:0]       saturation_o,
  output logic [rgbhsv_pkg::CHAN_W-1:0]      value_o
);

  localparam int unsigned DS = ((HUE_FRAC_BITS + 6) > (SAT_FRAC_BITS + 1)) ?
                               (HUE_FRAC_BITS + 6) : (SAT_FRAC_BITS + 1);
  localparam int unsigned CW = rgbhsv_pkg::CHAN_W;

  logic              fe_valid, dv_valid;
  rgbhsv_pkg::side_t fe_side, dv_side;
  logic [CW-1:0]     hrem, hdiv, srem;
  logic [DS-1:0]     hlo, slo, hq, sq;

  assign busy = 1'b0;

  rgbhsv_front #(
    .HF (HUE_FRAC_BITS),
    .SF (SAT_FRAC_BITS),
    .DS (DS)
  ) u_front (
    .clk_i   (clk_i),
    .rst_ni  (rst_ni),
    .valid_i (start && !busy),
    .red_i   (red_i),
    .green_i (green_i),
    .blue_i  (blue_i),
    .valid_o (fe_valid),
    .side_o  (fe_side),
    .hrem_o  (hrem),
    .hlo_o   (hlo),
    .hdiv_o  (hdiv),
    .srem_o  (srem),
    .slo_o   (slo)
  );

  rgbhsv_div #(
    .DS (DS)
  ) u_div (
    .clk_i   (clk_i),
    .rst_ni  (rst_ni),
    .valid_i (fe_valid),
    .side_i  (fe_side),
    .hrem_i  (hrem),
    .hlo_i   (hlo),
    .hdiv_i  (hdiv),
    .srem_i  (srem),
    .slo_i   (slo),
    .valid_o (dv_valid),
    .side_o  (dv_side),
    .hq_o    (hq),
    .sq_o    (sq)
  );

  rgbhsv_back #(
    .HF (HUE_FRAC_BITS),
    .SF (SAT_FRAC_BITS),
    .DS (DS)
  ) u_back (
    .clk_i        (clk_i),
    .rst_ni       (rst_ni),
    .valid_i      (dv_valid),
    .side_i       (dv_side),
    .hq_i         (hq),
    .sq_i         (sq),
    .valid_o      (valid_o),
    .hue_o        (hue_o),
    .saturation_o (saturation_o),
    .value_o      (value_o)
  );

endmodule

`default_nettype wire
